// File: sv/vad_pkg.sv
`default_nettype none
package vad_pkg;

	// Step counts of the iterative units, one register stage per step
	localparam int SQP_STEPS    = 24;  // root bits of |p|^2 (48 bit value)
	localparam int SQS_STEPS    = 20;  // root bits of |s|^2 (40 bit value)
	localparam int DIV_STEPS    = 19;  // quotient bits, |c| stays below 4.0
	localparam int SQC_STEPS    = 17;  // root bits of 1 - c^2
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_SHIFT = 14;

	// Stage numbers along the pipeline
	localparam int ST_SEL    = 1;
	localparam int ST_MUL    = 2;
	localparam int ST_SUM    = 3;
	localparam int ST_DEN    = ST_SUM + SQP_STEPS + 1;
	localparam int ST_SQR    = ST_DEN + DIV_STEPS + 1;
	localparam int ST_CSET   = ST_SQR + SQC_STEPS + 1;
	localparam int ST_OUT    = ST_CSET + CORDIC_STEPS + 1;
	localparam int LAT       = ST_OUT;

	localparam logic [16:0]        ONE_Q16   = 17'd65536;
	localparam logic [15:0]        ANGLE_MAX = 16'd46080;
	localparam logic signed [25:0] DEG90     = 26'sd5898240;

	typedef struct packed {
		logic       valid;
		logic [7:0] tag;
		logic       undef;
	} side_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic signed [25:0] atan_deg(input int i);
		logic signed [25:0] a;
		unique case (i)
			0: a = 26'sd2949120;
			1: a = 26'sd1740967;
			2: a = 26'sd919879;
			3: a = 26'sd466945;
			4: a = 26'sd234379;
			5: a = 26'sd117304;
			6: a = 26'sd58666;
			7: a = 26'sd29335;
			8: a = 26'sd14668;
			9: a = 26'sd7334;
			10: a = 26'sd3667;
			11: a = 26'sd1833;
			12: a = 26'sd917;
			13: a = 26'sd458;
			14: a = 26'sd229;
			15: a = 26'sd115;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// File: sv/vector_angle_degrees.sv
`default_nettype none
// Angle in degrees between a track momentum and its road slope vector.
//
// Request channel: drive the track fields and raise start; a request is
// taken at every rising edge with start high and busy low. busy never
// rises, so a new request may enter on every clock.
// Result channel: strobe is high for exactly one cycle per request, with
// tag_out, angle_deg (unsigned Q8.8 degrees) and undefined. The receiver
// cannot hold results off, and none is needed: nothing ever waits.
// Results leave in request order.
// Throughput: one request per cycle. Every step of the square roots,
// the divider and the CORDIC has its own register stage, so the deepest
// logic between registers is one wide subtract/compare or one multiply.
// Pipeline: select and slope sign, products, sums, 24 root steps for
// |p| (|s| in parallel), denominator, 19 divide steps, clamp and
// square, 17 root steps for sin, CORDIC setup, 16 CORDIC steps, output.
// Reset: arst_n clears all valid bits at once; requests in flight are
// dropped and no strobe follows for them. Data registers are not reset.
// Zero momentum: undefined is set and angle_deg is 0.
module vector_angle_degrees
	import vad_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [7:0]          track_index,
	input  wire logic signed [23:0]  proj_x,
	input  wire logic signed [23:0]  proj_y,
	input  wire logic signed [23:0]  proj_z,
	input  wire logic signed [23:0]  gap_px,
	input  wire logic signed [23:0]  gap_py,
	input  wire logic signed [23:0]  gap_pz,
	input  wire logic signed [23:0]  fallback_px,
	input  wire logic signed [23:0]  fallback_py,
	input  wire logic signed [23:0]  fallback_pz,
	input  wire logic signed [19:0]  slope_x,
	input  wire logic signed [19:0]  slope_y,
	output logic                     strobe,
	output logic [7:0]               tag_out,
	output logic [15:0]              angle_deg,
	output logic                     undefined
);

	// ---------------- sideband shift line: valid, tag, zero-length flag
	side_t side_s [1:LAT];
	side_t side_d [1:LAT];
	logic  zero_len;

	assign busy = 1'b0;

	always_comb begin
		side_d[1].valid = start;
		side_d[1].tag   = track_index;
		side_d[1].undef = 1'b0;
		for (int k = 2; k <= LAT; k++) begin
			side_d[k] = side_s[k-1];
		end
		// the flag is known once the squared length is summed
		side_d[ST_SUM].undef = zero_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAT; k++) begin
				side_s[k] <= '0;
			end
		end else begin
			for (int k = 1; k <= LAT; k++) begin
				side_s[k] <= side_d[k];
			end
		end
	end

	// ---------------- stage 1: pick momentum, orient slope
	logic                absent;
	logic signed [23:0]  px_s1, py_s1, pz_s1;
	logic signed [20:0]  sx_s1, sy_s1;
	logic                szneg_s1;

	assign absent = (proj_x == 24'sd0) && (proj_y == 24'sd0) && (proj_z == 24'sd0);

	always_ff @(posedge clk) begin
		logic signed [23:0] pz_sel;
		pz_sel = absent ? fallback_pz : gap_pz;
		px_s1    <= absent ? fallback_px : gap_px;
		py_s1    <= absent ? fallback_py : gap_py;
		pz_s1    <= pz_sel;
		szneg_s1 <= pz_sel[23];
		// flip the slope vector when the track runs backward in z
		sx_s1    <= pz_sel[23] ? -21'(slope_x) : 21'(slope_x);
		sy_s1    <= pz_sel[23] ? -21'(slope_y) : 21'(slope_y);
	end

	// ---------------- stage 2: products
	logic signed [47:0] pxx_s2, pyy_s2, pzz_s2;
	logic signed [44:0] dx_s2, dy_s2;
	logic signed [40:0] dz_s2;
	logic signed [41:0] sxx_s2, syy_s2;

	always_ff @(posedge clk) begin
		pxx_s2 <= px_s1 * px_s1;
		pyy_s2 <= py_s1 * py_s1;
		pzz_s2 <= pz_s1 * pz_s1;
		dx_s2  <= 45'(px_s1) * 45'(sx_s1);
		dy_s2  <= 45'(py_s1) * 45'(sy_s1);
		dz_s2  <= szneg_s1 ? -(41'(pz_s1) <<< 16) : (41'(pz_s1) <<< 16);
		sxx_s2 <= 42'(sx_s1) * 42'(sx_s1);
		syy_s2 <= 42'(sy_s1) * 42'(sy_s1);
	end

	// ---------------- stage 3: sums
	logic [47:0]        pp_d;
	logic [47:0]        pp_s3;
	logic [39:0]        ss_s3;
	logic signed [45:0] dot_s3;

	assign pp_d     = 48'(pxx_s2) + 48'(pyy_s2) + 48'(pzz_s2);
	assign zero_len = (pp_d == 48'd0);

	always_ff @(posedge clk) begin
		pp_s3  <= pp_d;
		ss_s3  <= 40'(sxx_s2) + 40'(syy_s2) + 40'h1_0000_0000;
		dot_s3 <= 46'(dx_s2) + 46'(dy_s2) + 46'(dz_s2);
	end

	// ---------------- root of |p|^2 and |s|^2, one bit pair per stage
	logic [48:0]        sqp_v_s [0:SQP_STEPS];
	logic [48:0]        sqp_r_s [0:SQP_STEPS];
	logic [40:0]        sqs_v_s [0:SQP_STEPS];
	logic [40:0]        sqs_r_s [0:SQP_STEPS];
	logic signed [45:0] dotp_s  [0:SQP_STEPS];

	assign sqp_v_s[0] = 49'(pp_s3);
	assign sqp_r_s[0] = '0;
	assign sqs_v_s[0] = 41'(ss_s3);
	assign sqs_r_s[0] = '0;
	assign dotp_s[0]  = dot_s3;

	for (genvar j = 1; j <= SQP_STEPS; j++) begin : g_sqp
		localparam logic [48:0] PBIT = 49'd1 << (2 * (SQP_STEPS - j));
		always_ff @(posedge clk) begin
			if (sqp_v_s[j-1] >= sqp_r_s[j-1] + PBIT) begin
				sqp_v_s[j] <= sqp_v_s[j-1] - (sqp_r_s[j-1] + PBIT);
				sqp_r_s[j] <= (sqp_r_s[j-1] >> 1) + PBIT;
			end else begin
				sqp_v_s[j] <= sqp_v_s[j-1];
				sqp_r_s[j] <= sqp_r_s[j-1] >> 1;
			end
			dotp_s[j] <= dotp_s[j-1];
		end
		if (j <= SQS_STEPS) begin : g_sqs
			localparam logic [40:0] SBIT = 41'd1 << (2 * (SQS_STEPS - j));
			always_ff @(posedge clk) begin
				if (sqs_v_s[j-1] >= sqs_r_s[j-1] + SBIT) begin
					sqs_v_s[j] <= sqs_v_s[j-1] - (sqs_r_s[j-1] + SBIT);
					sqs_r_s[j] <= (sqs_r_s[j-1] >> 1) + SBIT;
				end else begin
					sqs_v_s[j] <= sqs_v_s[j-1];
					sqs_r_s[j] <= sqs_r_s[j-1] >> 1;
				end
			end
		end else begin : g_sqs_hold
			always_ff @(posedge clk) begin
				sqs_v_s[j] <= sqs_v_s[j-1];
				sqs_r_s[j] <= sqs_r_s[j-1];
			end
		end
	end

	// ---------------- denominator and dot magnitude
	logic [43:0] den_sd;
	logic [44:0] mag_sd;
	logic        cneg_sd;

	always_ff @(posedge clk) begin
		den_sd  <= sqp_r_s[SQP_STEPS][23:0] * sqs_r_s[SQP_STEPS][19:0];
		mag_sd  <= dotp_s[SQP_STEPS][45] ? 45'(-dotp_s[SQP_STEPS])
		                                 : 45'(dotp_s[SQP_STEPS]);
		cneg_sd <= dotp_s[SQP_STEPS][45];
	end

	// ---------------- restoring divide, one quotient bit per stage
	logic [62:0]          dv_rem_s [0:DIV_STEPS];
	logic [43:0]          dv_den_s [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_q_s   [0:DIV_STEPS];
	logic                 dv_neg_s [0:DIV_STEPS];

	// round to nearest: add half the denominator up front
	assign dv_rem_s[0] = (63'(mag_sd) << 16) + 63'(den_sd >> 1);
	assign dv_den_s[0] = den_sd;
	assign dv_q_s[0]   = '0;
	assign dv_neg_s[0] = cneg_sd;

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		localparam int K = DIV_STEPS - j;
		localparam logic [DIV_STEPS-1:0] QBIT = {{(DIV_STEPS-1){1'b0}}, 1'b1} << K;
		logic [62:0] sub;
		assign sub = 63'(dv_den_s[j-1]) << K;
		always_ff @(posedge clk) begin
			if (dv_rem_s[j-1] >= sub) begin
				dv_rem_s[j] <= dv_rem_s[j-1] - sub;
				dv_q_s[j]   <= dv_q_s[j-1] | QBIT;
			end else begin
				dv_rem_s[j] <= dv_rem_s[j-1];
				dv_q_s[j]   <= dv_q_s[j-1];
			end
			dv_den_s[j] <= dv_den_s[j-1];
			dv_neg_s[j] <= dv_neg_s[j-1];
		end
	end

	// ---------------- clamp |c| to 1.0 and square it
	logic [16:0] qc;
	logic [16:0] qc_sq;
	logic [33:0] qq_sq;
	logic        cneg_sq;

	assign qc = (dv_q_s[DIV_STEPS] > 19'(ONE_Q16)) ? ONE_Q16
	                                               : dv_q_s[DIV_STEPS][16:0];

	always_ff @(posedge clk) begin
		qc_sq   <= qc;
		qq_sq   <= qc * qc;
		cneg_sq <= dv_neg_s[DIV_STEPS];
	end

	// ---------------- sin = root(1 - c^2)
	logic [33:0] sqc_v_s [0:SQC_STEPS];
	logic [33:0] sqc_r_s [0:SQC_STEPS];
	logic [16:0] sqc_c_s [0:SQC_STEPS];
	logic        sqc_n_s [0:SQC_STEPS];

	assign sqc_v_s[0] = 34'h1_0000_0000 - qq_sq;
	assign sqc_r_s[0] = '0;
	assign sqc_c_s[0] = qc_sq;
	assign sqc_n_s[0] = cneg_sq;

	for (genvar j = 1; j <= SQC_STEPS; j++) begin : g_sqc
		localparam logic [33:0] CBIT = 34'd1 << (2 * (SQC_STEPS - j));
		always_ff @(posedge clk) begin
			if (sqc_v_s[j-1] >= sqc_r_s[j-1] + CBIT) begin
				sqc_v_s[j] <= sqc_v_s[j-1] - (sqc_r_s[j-1] + CBIT);
				sqc_r_s[j] <= (sqc_r_s[j-1] >> 1) + CBIT;
			end else begin
				sqc_v_s[j] <= sqc_v_s[j-1];
				sqc_r_s[j] <= sqc_r_s[j-1] >> 1;
			end
			sqc_c_s[j] <= sqc_c_s[j-1];
			sqc_n_s[j] <= sqc_n_s[j-1];
		end
	end

	// ---------------- CORDIC vectoring on (c, s)
	logic signed [33:0] cx_s [0:CORDIC_STEPS];
	logic signed [33:0] cy_s [0:CORDIC_STEPS];
	logic signed [25:0] cz_s [0:CORDIC_STEPS];

	always_ff @(posedge clk) begin
		logic signed [33:0] sv, cv;
		sv = 34'(sqc_r_s[SQC_STEPS][16:0]) <<< CORDIC_SHIFT;
		cv = 34'(sqc_c_s[SQC_STEPS]) <<< CORDIC_SHIFT;
		// negative cosine: rotate by 90 degrees first; a negative dot that
		// rounds to a zero cosine takes the positive path
		if (sqc_n_s[SQC_STEPS] && sqc_c_s[SQC_STEPS] != 17'd0) begin
			cx_s[0] <= sv;
			cy_s[0] <= cv;
			cz_s[0] <= DEG90;
		end else begin
			cx_s[0] <= cv;
			cy_s[0] <= sv;
			cz_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_cordic
		localparam int I = j - 1;
		localparam logic signed [25:0] ATAN = atan_deg(I);
		logic signed [33:0] dxv, dyv;
		assign dxv = cy_s[j-1] >>> I;
		assign dyv = cx_s[j-1] >>> I;
		always_ff @(posedge clk) begin
			if (cy_s[j-1] > 34'sd0) begin
				cx_s[j] <= cx_s[j-1] + dxv;
				cy_s[j] <= cy_s[j-1] - dyv;
				cz_s[j] <= cz_s[j-1] + ATAN;
			end else begin
				cx_s[j] <= cx_s[j-1] - dxv;
				cy_s[j] <= cy_s[j-1] + dyv;
				cz_s[j] <= cz_s[j-1] - ATAN;
			end
		end
	end

	// ---------------- output: clamp, round to Q8.8, clamp; zero when undefined
	logic signed [25:0] zf;
	logic [25:0]        zpos;
	logic [17:0]        zr;
	logic [15:0]        angle_so;

	assign zf   = cz_s[CORDIC_STEPS];
	assign zpos = zf[25] ? 26'd0 : 26'(zf);
	assign zr   = 18'((zpos + 26'd128) >> 8);

	always_ff @(posedge clk) begin
		if (side_s[LAT-1].undef) begin
			angle_so <= '0;
		end else if (zr > 18'(ANGLE_MAX)) begin
			angle_so <= ANGLE_MAX;
		end else begin
			angle_so <= zr[15:0];
		end
	end

	assign strobe    = side_s[LAT].valid;
	assign tag_out   = side_s[LAT].tag;
	assign undefined = side_s[LAT].valid & side_s[LAT].undef;
	assign angle_deg = angle_so;

	// ---------------- assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		side_s[1].valid |-> ##(LAT-1) strobe)
		else $error("request lost in the pipeline");

	a_tag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		side_s[1].valid |-> ##(LAT-1) (tag_out == $past(side_s[1].tag, LAT-1)))
		else $error("tag changed in flight");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		undefined |-> (strobe && angle_deg == 16'd0))
		else $error("zero-length momentum with nonzero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (angle_deg <= ANGLE_MAX))
		else $error("angle above 180 degrees");

endmodule
`default_nettype wire
